>>> src/sjfr_pkg.sv
// ----------------------------------------------------------------------------
// sjfr_pkg: shared types and helpers for the shift-jis find and replace block
// transaction structs, config register indexes, cell control and byte classes
// ----------------------------------------------------------------------------
package sjfr_pkg;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int RESULT_LIMIT = 16;
    localparam int RESULT_CNT_W = 5;

    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [7:0] LEAD_BASE = 8'hA1;
    localparam logic [7:0] LEAD_SPAN = 8'h3B;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_CASE_SENSITIVE     = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_REPL,
        ST_POP,
        ST_MARK
    } seq_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic head;
        logic active;
        logic final_pos;
        logic case_sens;
    } cell_ctrl_t;

    typedef struct packed {
        logic trail;
        logic match;
    } cell_link_t;

    function automatic logic is_lead(input logic [7:0] b);
        logic [7:0] d;
        d = (b ^ CASE_GAP) - LEAD_BASE;
        return d <= LEAD_SPAN;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= LOWER_A && b <= LOWER_Z) ? (b - CASE_GAP) : b;
    endfunction

endpackage

>>> src/sjfr_cell.sv
// ----------------------------------------------------------------------------
// sjfr_cell: one position of the candidate window
// holds one byte, compares it with its pattern byte and passes the trail and
// match flags on to the next position
// ----------------------------------------------------------------------------
module sjfr_cell (
    input  logic                 aclk,
    input  sjfr_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           pat_byte,
    input  logic [7:0]           next_byte,
    input  sjfr_pkg::cell_link_t link_in,
    output sjfr_pkg::cell_link_t link_out,
    output logic [7:0]           byte_q,
    output logic [7:0]           eff_byte
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       exact_eq;
    logic       fold_eq;
    logic       lead;
    logic       pos_ok;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.load) begin
            byte_next = in_byte;
        end else if (ctrl.shift) begin
            byte_next = next_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // the byte being written this cycle takes part in the compare at once
    assign eff_byte = ctrl.load ? in_byte : byte_reg;
    assign byte_q   = byte_reg;

    assign exact_eq = (eff_byte == pat_byte);
    assign fold_eq  = (sjfr_pkg::fold(eff_byte) == sjfr_pkg::fold(pat_byte));
    assign lead     = sjfr_pkg::is_lead(eff_byte);

    always_comb begin
        if (ctrl.case_sens) begin
            pos_ok = exact_eq;
        end else if (ctrl.head) begin
            pos_ok = fold_eq;
        end else if (link_in.trail) begin
            pos_ok = exact_eq;
        end else begin
            // a lead byte in the final position has no room for its trail
            pos_ok = fold_eq && !(lead && ctrl.final_pos);
        end
    end

    assign link_out.trail = !ctrl.head && !link_in.trail && lead;
    assign link_out.match = link_in.match && (!ctrl.active || pos_ok);

endmodule

>>> src/sjis_find_and_replace.sv
// ----------------------------------------------------------------------------
// sjis_find_and_replace: streaming substring replace over shift-jis text
// each hit is replaced by the replacement bytes and held bytes are flushed at string end;
// results leave through one registered result port
// aresetn (sync, low) clears sequencer, counters and config; cell bytes hold until written
// ----------------------------------------------------------------------------
module sjis_find_and_replace #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sjfr_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sjfr_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [sjfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sjfr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int RW  = (MAX_REPLACEMENT < 1) ? 1 : $clog2(MAX_REPLACEMENT + 1);
    localparam int RIW = (MAX_REPLACEMENT <= 2) ? 1 : $clog2(MAX_REPLACEMENT);
    localparam int REG_BYTES = sjfr_pkg::CFG_DATA_W / 8;
    localparam int NW  = sjfr_pkg::RESULT_CNT_W;

    // configuration
    logic [sjfr_pkg::CFG_DATA_W-1:0] pattern_reg;
    logic [3:0]                      plen_reg;
    logic [sjfr_pkg::CFG_DATA_W-1:0] repl_reg;
    logic [3:0]                      rlen_reg;
    logic                            cs_reg;

    // sequencer and window control
    sjfr_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pass_reg, pass_next;
    logic [RW-1:0]   rep_left_reg, rep_left_next;
    logic [RIW-1:0]  rep_idx_reg, rep_idx_next;
    logic [CW-1:0]   drop_left_reg, drop_left_next;
    logic [CW-1:0]   pop_left_reg, pop_left_next;
    logic            last_reg, last_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [7:0]      direct_byte_reg;

    // result register
    logic                m_valid_reg, m_valid_next;
    sjfr_pkg::out_item_t m_data_reg;

    // cell row
    sjfr_pkg::cell_ctrl_t cell_ctrl [MAX_PATTERN];
    sjfr_pkg::cell_link_t link      [MAX_PATTERN+1];
    logic [7:0]           pat_b     [MAX_PATTERN];
    logic [7:0]           nxt_b     [MAX_PATTERN];
    logic [7:0]           cell_q    [MAX_PATTERN];
    logic [7:0]           cell_eff  [MAX_PATTERN];

    logic [CW-1:0] len_eff;
    logic [RW-1:0] rlen_eff;
    logic          accept;
    logic          push_now;
    logic          shift_en;
    logic [CW-1:0] c_w;
    logic          eval_now;
    logic          hit;
    logic          lead0;
    logic [CW-1:0] drop_a;
    logic [CW-1:0] base_a;
    logic [CW-1:0] pops_a;
    logic [CW-1:0] count_a;
    logic          pass_a;
    logic [RW-1:0] rep_a;

    logic                emit_req;
    sjfr_pkg::out_item_t emit_data;
    logic                out_free;
    logic                suppress;
    logic                go;
    logic                load_out;
    logic                at_limit_edge;
    logic [7:0]          rep_byte;

    // ------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= 4'd0;
            cs_reg      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sjfr_pkg::REG_PATTERN_BYTES:      pattern_reg <= cfg_wdata;
                sjfr_pkg::REG_PATTERN_LENGTH:     plen_reg    <= cfg_wdata[3:0];
                sjfr_pkg::REG_REPLACEMENT_BYTES:  repl_reg    <= cfg_wdata;
                sjfr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg    <= cfg_wdata[3:0];
                sjfr_pkg::REG_CASE_SENSITIVE:     cs_reg      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // lengths saturate at the window and replacement limits
    assign len_eff  = (5'(plen_reg) > 5'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(plen_reg);
    assign rlen_eff = (5'(rlen_reg) > 5'(MAX_REPLACEMENT)) ?
                      RW'(MAX_REPLACEMENT) : RW'(rlen_reg);

    // ------------------------------------------------------------------
    // cell row
    assign link[0] = '{trail: 1'b0, match: 1'b1};

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        if (g < REG_BYTES) begin : g_pat
            assign pat_b[g] = pattern_reg[8*g +: 8];
        end else begin : g_pat_zero
            assign pat_b[g] = 8'h00;
        end

        if (g == MAX_PATTERN - 1) begin : g_tail
            assign nxt_b[g] = cell_q[g];
        end else begin : g_link
            assign nxt_b[g] = cell_q[g+1];
        end

        assign cell_ctrl[g].load      = push_now && (count_reg == CW'(g));
        assign cell_ctrl[g].shift     = shift_en;
        assign cell_ctrl[g].head      = 1'(g == 0);
        assign cell_ctrl[g].active    = CW'(g) < len_eff;
        assign cell_ctrl[g].final_pos = CW'(g) == (len_eff - CW'(1));
        assign cell_ctrl[g].case_sens = cs_reg;

        sjfr_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[g]),
            .in_byte   (s_data.in_byte),
            .pat_byte  (pat_b[g]),
            .next_byte (nxt_b[g]),
            .link_in   (link[g]),
            .link_out  (link[g+1]),
            .byte_q    (cell_q[g]),
            .eff_byte  (cell_eff[g])
        );
    end

    // ------------------------------------------------------------------
    // decision on the accepted byte
    assign s_ready  = (state_reg == sjfr_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign push_now = accept && !pass_reg && (count_reg < CW'(MAX_PATTERN));

    assign c_w      = push_now ? (count_reg + CW'(1)) : count_reg;
    assign eval_now = !pass_reg && (c_w >= len_eff);
    assign hit      = eval_now && (len_eff != '0) && link[MAX_PATTERN].match;
    assign lead0    = sjfr_pkg::is_lead(cell_eff[0]);

    always_comb begin
        drop_a = hit ? len_eff : '0;
        base_a = '0;
        if (eval_now && !hit) begin
            // a lead byte leaves together with its trail byte when that is held
            if (lead0 && (c_w > CW'(1))) begin
                base_a = CW'(2);
            end else begin
                base_a = CW'(1);
            end
        end
        pops_a  = s_data.in_last ? (c_w - drop_a) : base_a;
        count_a = c_w - drop_a - pops_a;
        pass_a  = eval_now && !hit && lead0 && (c_w == CW'(1)) && !s_data.in_last;
        rep_a   = hit ? rlen_eff : '0;
    end

    // ------------------------------------------------------------------
    // replacement byte lookup
    always_comb begin
        rep_byte = 8'h00;
        for (int k = 0; k < REG_BYTES; k++) begin
            if (k < MAX_REPLACEMENT && rep_idx_reg == RIW'(k)) begin
                rep_byte = repl_reg[8*k +: 8];
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer outputs
    assign out_free      = !m_valid_reg || m_ready;
    assign suppress      = (n_reg == NW'(sjfr_pkg::RESULT_LIMIT));
    assign at_limit_edge = (n_reg == NW'(sjfr_pkg::RESULT_LIMIT - 1));

    always_comb begin
        emit_req  = 1'b0;
        emit_data = '0;
        unique case (state_reg)
            sjfr_pkg::ST_DIRECT: begin
                emit_req           = 1'b1;
                emit_data.out_byte = direct_byte_reg;
                emit_data.has_byte = 1'b1;
                emit_data.out_last = last_reg && ((pop_left_reg == '0) || at_limit_edge);
            end
            sjfr_pkg::ST_REPL: begin
                emit_req           = (rep_left_reg != '0);
                emit_data.out_byte = rep_byte;
                emit_data.has_byte = 1'b1;
                emit_data.out_last = last_reg && (((rep_left_reg == RW'(1)) &&
                                     (pop_left_reg == '0)) || at_limit_edge);
            end
            sjfr_pkg::ST_POP: begin
                emit_req           = 1'b1;
                emit_data.out_byte = cell_q[0];
                emit_data.has_byte = 1'b1;
                emit_data.out_last = last_reg && ((pop_left_reg == CW'(1)) || at_limit_edge);
            end
            sjfr_pkg::ST_MARK: begin
                // string ended with nothing to show
                emit_req           = 1'b1;
                emit_data.out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // results past the limit are consumed without showing
    assign go       = emit_req && (out_free || suppress);
    assign load_out = go && !suppress;
    assign shift_en = ((state_reg == sjfr_pkg::ST_REPL) && (drop_left_reg != '0)) ||
                      ((state_reg == sjfr_pkg::ST_POP) && go);

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sjfr_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (pass_reg) begin
                        state_next = sjfr_pkg::ST_DIRECT;
                    end else if (hit) begin
                        state_next = sjfr_pkg::ST_REPL;
                    end else if (pops_a != '0) begin
                        state_next = sjfr_pkg::ST_POP;
                    end else if (s_data.in_last) begin
                        state_next = sjfr_pkg::ST_MARK;
                    end else begin
                        state_next = sjfr_pkg::ST_IDLE;
                    end
                end
            end
            sjfr_pkg::ST_DIRECT: begin
                if (go) begin
                    state_next = (pop_left_reg != '0) ? sjfr_pkg::ST_POP : sjfr_pkg::ST_IDLE;
                end
            end
            sjfr_pkg::ST_REPL: begin
                if (((rep_left_reg == '0) || ((rep_left_reg == RW'(1)) && go)) &&
                    (drop_left_reg <= CW'(1))) begin
                    priority if (pop_left_reg != '0) begin
                        state_next = sjfr_pkg::ST_POP;
                    end else if (last_reg && (n_next == '0)) begin
                        state_next = sjfr_pkg::ST_MARK;
                    end else begin
                        state_next = sjfr_pkg::ST_IDLE;
                    end
                end
            end
            sjfr_pkg::ST_POP: begin
                if (go && (pop_left_reg == CW'(1))) begin
                    state_next = sjfr_pkg::ST_IDLE;
                end
            end
            sjfr_pkg::ST_MARK: begin
                if (go) begin
                    state_next = sjfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sjfr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // counters and window bookkeeping
    always_comb begin
        count_next     = count_reg;
        pass_next      = pass_reg;
        rep_left_next  = rep_left_reg;
        rep_idx_next   = rep_idx_reg;
        drop_left_next = drop_left_reg;
        pop_left_next  = pop_left_reg;
        last_next      = last_reg;
        n_next         = n_reg + NW'(load_out);
        if (accept) begin
            count_next     = count_a;
            pass_next      = pass_a;
            rep_left_next  = rep_a;
            rep_idx_next   = '0;
            drop_left_next = drop_a;
            pop_left_next  = pops_a;
            last_next      = s_data.in_last;
            n_next         = '0;
        end else begin
            if ((state_reg == sjfr_pkg::ST_REPL) && (drop_left_reg != '0)) begin
                drop_left_next = drop_left_reg - CW'(1);
            end
            if ((state_reg == sjfr_pkg::ST_REPL) && go) begin
                rep_left_next = rep_left_reg - RW'(1);
                rep_idx_next  = rep_idx_reg + RIW'(1);
            end
            if ((state_reg == sjfr_pkg::ST_POP) && go) begin
                pop_left_next = pop_left_reg - CW'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sjfr_pkg::ST_IDLE;
            count_reg     <= '0;
            pass_reg      <= 1'b0;
            rep_left_reg  <= '0;
            drop_left_reg <= '0;
            pop_left_reg  <= '0;
            last_reg      <= 1'b0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            rep_left_reg  <= rep_left_next;
            drop_left_reg <= drop_left_next;
            pop_left_reg  <= pop_left_next;
            last_reg      <= last_next;
            n_reg         <= n_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_idx_reg <= rep_idx_next;
        if (accept) begin
            direct_byte_reg <= s_data.in_byte;
        end
        if (load_out) begin
            m_data_reg <= emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PATTERN))
        else $error("window count past the cell row");

    a_result_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(sjfr_pkg::RESULT_LIMIT))
        else $error("result count past the limit");

    a_pass_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_reg |-> (count_reg == '0))
        else $error("trail byte pending with bytes held in the window");

    a_mark_only_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sjfr_pkg::ST_MARK) |-> (last_reg && (n_reg == '0)))
        else $error("end marker after results of the same transaction");

    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ((rep_left_reg == '0) && (drop_left_reg == '0) && (pop_left_reg == '0)))
        else $error("transaction taken while work is still queued");
`endif

endmodule
